// File: hw/rtl/pidf_pkg.sv
package pidf_pkg;

  localparam int POSITION_BITS_DEF = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GOAL_W     = 10;
  localparam int GAIN_W     = 16;
  localparam int SMOOTH_W   = 9;
  localparam int SUM_W      = 17;  // holds +/-65535
  localparam int DELTA_W    = 12;  // holds +/-2047
  localparam int FILT_W     = 20;  // Q11.8 filtered difference
  localparam int OUT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GOAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ILIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DLIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH   = 3'd7;

  typedef struct packed {
    logic [GOAL_W-1:0]   goal;
    logic [9:0]          deadband;
    logic [15:0]         ilimit;
    logic [10:0]         dlimit;
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [SMOOTH_W-1:0] smooth;
  } cfg_t;

endpackage

// File: hw/rtl/pidf_cfg_regs.sv
module pidf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             we,
  input  logic [pidf_pkg::CFG_IDX_W-1:0]   index,
  input  logic [pidf_pkg::CFG_DATA_W-1:0]  data,
  output pidf_pkg::cfg_t                   cfg
);

  pidf_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal     <= 10'd512;
      cfg_r.deadband <= '0;
      cfg_r.ilimit   <= 16'hFFFF;
      cfg_r.dlimit   <= 11'h7FF;
      cfg_r.gain_p   <= 16'd256;
      cfg_r.gain_i   <= '0;
      cfg_r.gain_d   <= '0;
      cfg_r.smooth   <= '0;
    end else if (we) begin
      case (index)
        pidf_pkg::REG_GOAL:     cfg_r.goal     <= data[9:0];
        pidf_pkg::REG_DEADBAND: cfg_r.deadband <= data[9:0];
        pidf_pkg::REG_ILIMIT:   cfg_r.ilimit   <= data[15:0];
        pidf_pkg::REG_DLIMIT:   cfg_r.dlimit   <= data[10:0];
        pidf_pkg::REG_GAIN_P:   cfg_r.gain_p   <= data[15:0];
        pidf_pkg::REG_GAIN_I:   cfg_r.gain_i   <= data[15:0];
        pidf_pkg::REG_GAIN_D:   cfg_r.gain_d   <= data[15:0];
        pidf_pkg::REG_SMOOTH:   cfg_r.smooth   <= data[8:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/pidf_smac.sv
// Bit-serial multiply-accumulate, multiplier bits MSB first (Horner form):
// acc = 2*acc + sum of operands whose bit is set.
module pidf_smac #(
  parameter int AW = 44
) (
  input  logic                 clk,
  input  logic                 clr,
  input  logic                 en,
  input  logic [2:0]           bits,
  input  logic signed [AW-1:0] op0,
  input  logic signed [AW-1:0] op1,
  input  logic signed [AW-1:0] op2,
  output logic signed [AW-1:0] acc
);

  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r <<< 1;
    if (bits[0]) acc_nxt = acc_nxt + op0;
    if (bits[1]) acc_nxt = acc_nxt + op1;
    if (bits[2]) acc_nxt = acc_nxt + op2;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/pid_regulator_deadband_filtered_d_top.sv
// One item at a time: the input is stalled from the transaction until the result is
// registered; inside the deadband the MAC steps are skipped.
// The bit-serial MAC runs first over the bits of the smoothing weight,
// then over the bits of the three gains in parallel.
// Reset (synchronous, rst_n low): registers to defaults, integral, filtered
// difference and previous error cleared, no result pending.
module pid_regulator_deadband_filtered_d_top #(
  parameter int POSITION_BITS = pidf_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [POSITION_BITS-1:0]              in_position,
  input  logic                                  in_mission_mode,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidf_pkg::OUT_W-1:0]     out_correction,
  output logic                                  out_in_deadband,
  output logic                                  out_last_error_positive,
  input  logic                                  cfg_we,
  input  logic [pidf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int GW  = pidf_pkg::GOAL_W;
  localparam int EW  = ((POSITION_BITS > GW) ? POSITION_BITS : GW) + 1;
  localparam int SW  = pidf_pkg::SUM_W;
  localparam int SPW = ((SW > EW) ? SW : EW) + 1;
  localparam int DW  = pidf_pkg::DELTA_W;
  localparam int FW  = pidf_pkg::FILT_W;
  localparam int AW  = ((EW + 26 > 42) ? EW + 26 : 42) + 2;
  localparam int KW  = pidf_pkg::GAIN_W;
  localparam int MW  = pidf_pkg::SMOOTH_W;
  localparam logic signed [AW-1:0] CMAX = AW'(32767);
  localparam logic signed [AW-1:0] CMIN = ~CMAX;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_FLT, S_RND, S_OUT, S_FIN} state_t;

  pidf_pkg::cfg_t cfg;

  pidf_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  state_t                state_r;
  logic [3:0]            cnt_r;
  logic signed [EW-1:0]  err_r;
  logic                  mission_r;
  logic                  db_r;
  logic signed [SW-1:0]  sum_r;
  logic signed [DW-1:0]  diff_r;
  logic signed [FW-1:0]  filt_r;
  logic [KW-1:0]         sh_p_r, sh_i_r, sh_d_r;

  logic signed [SW-1:0]  error_sum_r;
  logic signed [FW-1:0]  smooth_r;
  logic signed [EW-1:0]  prev_r;

  logic                  out_valid_r;
  logic signed [pidf_pkg::OUT_W-1:0] out_corr_r;
  logic                  out_db_r;
  logic                  out_lep_r;

  // input error
  logic signed [EW-1:0]  err_in;
  assign err_in = $signed({{(EW-POSITION_BITS){1'b0}}, in_position})
                - $signed({{(EW-GW){1'b0}}, cfg.goal});

  // deadband test
  logic [EW-1:0] mag;
  logic          in_db;
  assign mag   = (err_r < 0) ? $unsigned(-err_r) : $unsigned(err_r);
  assign in_db = mag < {{(EW-10){1'b0}}, cfg.deadband};

  // clamped integral
  logic signed [SPW-1:0] sum_raw, ilim, sum_cl;
  assign sum_raw = SPW'(error_sum_r) + SPW'(err_r);
  assign ilim    = $signed({{(SPW-16){1'b0}}, cfg.ilimit});
  assign sum_cl  = (sum_raw > ilim) ? ilim : ((sum_raw < -ilim) ? -ilim : sum_raw);

  // clamped difference
  logic signed [EW:0] diff_raw, dlim, diff_cl;
  assign diff_raw = (EW+1)'(err_r) - (EW+1)'(prev_r);
  assign dlim     = $signed({{(EW-10){1'b0}}, cfg.dlimit});
  assign diff_cl  = (diff_raw > dlim) ? dlim : ((diff_raw < -dlim) ? -dlim : diff_raw);

  logic [MW-1:0] s_eff;
  assign s_eff = (cfg.smooth > MW'(256)) ? MW'(256) : cfg.smooth;

  // serial MAC
  logic signed [AW-1:0] acc, op0, op1, op2;
  logic                 mac_clr, mac_en;

  // filter: s*(S - 256*D) + 65536*D; output: 256*(kp*e + ki*sum) + kd*filt
  assign op0 = (state_r == S_FLT) ? (AW'(smooth_r) - (AW'(diff_r) <<< 8))
                                  : (AW'(err_r) <<< 8);
  assign op1 = AW'(sum_r) <<< 8;
  assign op2 = AW'(filt_r);
  assign mac_clr = ((state_r == S_PREP) && !in_db) || (state_r == S_RND);
  assign mac_en  = (state_r == S_FLT) || (state_r == S_OUT);

  pidf_smac #(.AW(AW)) u_mac (
    .clk  (clk),
    .clr  (mac_clr),
    .en   (mac_en),
    .bits ({sh_d_r[KW-1], sh_i_r[KW-1], sh_p_r[KW-1]}),
    .op0  (op0),
    .op1  (op1),
    .op2  (op2),
    .acc  (acc)
  );

  // rounding of filter numerator, halves away from zero
  logic signed [AW-1:0] num, num_abs, rnd;
  assign num     = acc + (AW'(diff_r) <<< 16);
  assign num_abs = (num < 0) ? -num : num;
  assign rnd     = (num < 0) ? -((num_abs + AW'(128)) >>> 8) : ((num_abs + AW'(128)) >>> 8);

  // output: truncate toward zero, saturate
  logic signed [AW-1:0] q_in, q, corr_sat;
  assign q_in     = (acc < 0) ? (acc + AW'(65535)) : acc;
  assign q        = q_in >>> 16;
  assign corr_sat = (q > CMAX) ? CMAX : ((q < CMIN) ? CMIN : q);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      db_r        <= 1'b0;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      smooth_r    <= '0;
      prev_r      <= '0;
    end else begin
      // S_FIN reloads the result register in the same cycle
      if (out_valid_r && !out_stall && (state_r != S_FIN)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            err_r     <= err_in;
            mission_r <= in_mission_mode;
            state_r   <= S_PREP;
          end
        end
        S_PREP: begin
          db_r   <= in_db;
          sum_r  <= sum_cl[SW-1:0];
          diff_r <= diff_cl[DW-1:0];
          sh_p_r <= {s_eff, {(KW-MW){1'b0}}};
          sh_i_r <= '0;
          sh_d_r <= '0;
          cnt_r  <= 4'(MW - 1);
          state_r <= in_db ? S_FIN : S_FLT;
        end
        S_FLT: begin
          sh_p_r <= sh_p_r << 1;
          cnt_r  <= cnt_r - 4'd1;
          if (cnt_r == '0) state_r <= S_RND;
        end
        S_RND: begin
          filt_r <= rnd[FW-1:0];
          if (!mission_r) sum_r <= '0;
          sh_p_r <= cfg.gain_p;
          sh_i_r <= cfg.gain_i;
          sh_d_r <= cfg.gain_d;
          cnt_r  <= 4'(KW - 1);
          state_r <= S_OUT;
        end
        S_OUT: begin
          sh_p_r <= sh_p_r << 1;
          sh_i_r <= sh_i_r << 1;
          sh_d_r <= sh_d_r << 1;
          cnt_r  <= cnt_r - 4'd1;
          if (cnt_r == '0) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_db_r    <= db_r;
            if (db_r) begin
              out_corr_r <= '0;
              out_lep_r  <= prev_r > 0;
            end else begin
              out_corr_r  <= corr_sat[pidf_pkg::OUT_W-1:0];
              out_lep_r   <= err_r > 0;
              error_sum_r <= sum_r;
              smooth_r    <= filt_r;
              prev_r      <= err_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall                = (state_r != S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_correction          = out_corr_r;
  assign out_in_deadband         = out_db_r;
  assign out_last_error_positive = out_lep_r;

endmodule
